### rtl/fpa_pkg.sv
package fpa_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int DATA_WIDTH = 64;
   localparam int INT_WIDTH = 32;
   localparam int DIV_WIDTH = DATA_WIDTH + FRACTION_BITS;
   localparam int CELL_COUNT = DIV_WIDTH;

   typedef enum logic [3:0] {
      OP_FROM_INT  = 4'd0,
      OP_TO_INT_RZ = 4'd1,
      OP_TO_INT_RN = 4'd2,
      OP_ADD       = 4'd3,
      OP_SUB       = 4'd4,
      OP_MUL       = 4'd5,
      OP_DIV       = 4'd6,
      OP_INT_ADD   = 4'd7,
      OP_INT_SUB   = 4'd8,
      OP_INT_MUL   = 4'd9,
      OP_INT_DIV   = 4'd10
   } op_type;

   // Work carried down the chain of cells beside the divider state.
   typedef struct packed {
      logic                    valid;
      logic                    is_div;
      logic                    negate;
      logic                    div_zero;
      logic [DATA_WIDTH-1:0]   early;
      logic [DIV_WIDTH-1:0]    dividend;
      logic [DATA_WIDTH-1:0]   divisor;
      logic [DATA_WIDTH:0]     remainder;
      logic [DIV_WIDTH-1:0]    quotient;
   } cell_type;

endpackage

### rtl/fpa_if.sv
interface fpa_req_if;
   import fpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [3:0]            operation;
   logic [DATA_WIDTH-1:0] operand_a;
   logic [DATA_WIDTH-1:0] operand_b;
   logic [INT_WIDTH-1:0]  int_operand;
   modport source (output valid, operation, operand_a, operand_b, int_operand, input ready);
   modport sink (input valid, operation, operand_a, operand_b, int_operand, output ready);
endinterface

interface fpa_rsp_if;
   import fpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result;
   logic                  divide_by_zero;
   modport source (output valid, result, divide_by_zero, input ready);
   modport sink (input valid, result, divide_by_zero, output ready);
endinterface

### rtl/fpa_div_cell.sv
module fpa_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fpa_pkg::cell_type cell_in,
   output fpa_pkg::cell_type cell_out
);
   import fpa_pkg::*;

   cell_type                cell_ff;
   cell_type                cell_in_w;
   logic [DATA_WIDTH:0]     shifted;
   logic [DATA_WIDTH+1:0]   diff;

   // One restoring division step: bring down the next dividend bit and subtract.
   always_comb begin
      cell_in_w = cell_in;
      shifted = {cell_in.remainder[DATA_WIDTH-1:0], cell_in.dividend[DIV_WIDTH-1]};
      diff = {1'b0, shifted} - {2'b00, cell_in.divisor};
      cell_in_w.dividend = {cell_in.dividend[DIV_WIDTH-2:0], 1'b0};
      if (cell_in.is_div && !diff[DATA_WIDTH+1]) begin
         cell_in_w.remainder = diff[DATA_WIDTH:0];
         cell_in_w.quotient = {cell_in.quotient[DIV_WIDTH-2:0], 1'b1};
      end else begin
         cell_in_w.remainder = shifted;
         cell_in_w.quotient = {cell_in.quotient[DIV_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule

### rtl/fpa_front.sv
module fpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [3:0]                    operation,
   input  logic [fpa_pkg::DATA_WIDTH-1:0] operand_a,
   input  logic [fpa_pkg::DATA_WIDTH-1:0] operand_b,
   input  logic [fpa_pkg::INT_WIDTH-1:0]  int_operand,
   output fpa_pkg::cell_type             cell_out
);
   import fpa_pkg::*;

   localparam int HALF_W = DATA_WIDTH / 2;

   // Stage one: magnitudes and 32x32 partial products; stage two: sums and setup.
   logic                    s1_valid_ff;
   logic [3:0]              s1_op_ff;
   logic [DATA_WIDTH-1:0]   s1_a_ff, s1_b_ff, s1_n_ff;
   logic                    s1_neg_ff, s1_bz_ff, s1_nz_ff;
   logic [DATA_WIDTH-1:0]   s1_p0_ff, s1_p1_ff, s1_p2_ff, s1_p3_ff;
   logic [DATA_WIDTH-1:0]   s1_q0_ff, s1_q1_ff, s1_q2_ff;
   logic [DATA_WIDTH-1:0]   s1_ma_ff, s1_mb_ff, s1_mn_ff;
   cell_type                cell_ff;
   cell_type                cell_in;

   logic [DATA_WIDTH-1:0]   a_w, b_w, n_w, ma_w, mb_w, mn_w, mul_b_w;
   logic                    neg_w;

   always_comb begin
      a_w = operand_a;
      b_w = operand_b;
      n_w = {{(DATA_WIDTH-INT_WIDTH){int_operand[INT_WIDTH-1]}}, int_operand};
      ma_w = a_w[DATA_WIDTH-1] ? (~a_w + 1'b1) : a_w;
      mb_w = b_w[DATA_WIDTH-1] ? (~b_w + 1'b1) : b_w;
      mn_w = n_w[DATA_WIDTH-1] ? (~n_w + 1'b1) : n_w;
      neg_w = a_w[DATA_WIDTH-1] ^ ((operation == OP_INT_DIV) ? n_w[DATA_WIDTH-1]
                                                             : b_w[DATA_WIDTH-1]);
      mul_b_w = mb_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= operation;
         s1_a_ff <= a_w;
         s1_b_ff <= b_w;
         s1_n_ff <= n_w;
         s1_neg_ff <= neg_w;
         s1_bz_ff <= (b_w == '0);
         s1_nz_ff <= (n_w == '0);
         s1_ma_ff <= ma_w;
         s1_mb_ff <= mb_w;
         s1_mn_ff <= mn_w;
         s1_p0_ff <= ma_w[HALF_W-1:0] * mul_b_w[HALF_W-1:0];
         s1_p1_ff <= ma_w[HALF_W-1:0] * mul_b_w[DATA_WIDTH-1:HALF_W];
         s1_p2_ff <= ma_w[DATA_WIDTH-1:HALF_W] * mul_b_w[HALF_W-1:0];
         s1_p3_ff <= ma_w[DATA_WIDTH-1:HALF_W] * mul_b_w[DATA_WIDTH-1:HALF_W];
         // Low 64 bits of a times a sign-extended integer.
         s1_q0_ff <= a_w[HALF_W-1:0] * n_w[HALF_W-1:0];
         s1_q1_ff <= a_w[HALF_W-1:0] * n_w[DATA_WIDTH-1:HALF_W];
         s1_q2_ff <= a_w[DATA_WIDTH-1:HALF_W] * n_w[HALF_W-1:0];
      end
   end

   logic [2*DATA_WIDTH-1:0] prod_w;
   logic [DATA_WIDTH-1:0]   mul_mag_w, imul_w, scaled_n_w, rz_w, rn_w, rn_mag_w, res_w;

   always_comb begin
      prod_w = {s1_p3_ff, s1_p0_ff}
             + {{HALF_W{1'b0}}, s1_p1_ff, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, s1_p2_ff, {HALF_W{1'b0}}};
      mul_mag_w = prod_w[DATA_WIDTH+FRACTION_BITS-1:FRACTION_BITS];
      imul_w = s1_q0_ff + {s1_q1_ff[HALF_W-1:0], {HALF_W{1'b0}}}
             + {s1_q2_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      scaled_n_w = s1_n_ff << FRACTION_BITS;
      rz_w = s1_ma_ff >> FRACTION_BITS;
      rn_mag_w = (s1_ma_ff + (DATA_WIDTH'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      if (s1_a_ff[DATA_WIDTH-1]) begin
         rz_w = ~rz_w + 1'b1;
         rn_w = ~rn_mag_w + 1'b1;
      end else begin
         rn_w = rn_mag_w;
      end
      rz_w = {{(DATA_WIDTH-INT_WIDTH){rz_w[INT_WIDTH-1]}}, rz_w[INT_WIDTH-1:0]};
      rn_w = {{(DATA_WIDTH-INT_WIDTH){rn_w[INT_WIDTH-1]}}, rn_w[INT_WIDTH-1:0]};
      case (s1_op_ff)
         OP_FROM_INT:  res_w = scaled_n_w;
         OP_TO_INT_RZ: res_w = rz_w;
         OP_TO_INT_RN: res_w = rn_w;
         OP_ADD:       res_w = s1_a_ff + s1_b_ff;
         OP_SUB:       res_w = s1_a_ff - s1_b_ff;
         OP_MUL:       res_w = s1_neg_ff ? (~mul_mag_w + 1'b1) : mul_mag_w;
         OP_INT_ADD:   res_w = s1_a_ff + scaled_n_w;
         OP_INT_SUB:   res_w = s1_a_ff - scaled_n_w;
         OP_INT_MUL:   res_w = imul_w;
         default:      res_w = '0;
      endcase

      cell_in = '0;
      cell_in.valid = s1_valid_ff;
      cell_in.negate = s1_neg_ff;
      cell_in.early = res_w;
      if (s1_op_ff == OP_DIV) begin
         cell_in.is_div = !s1_bz_ff;
         cell_in.div_zero = s1_bz_ff;
         cell_in.dividend = {s1_ma_ff, {FRACTION_BITS{1'b0}}};
         cell_in.divisor = s1_mb_ff;
         cell_in.early = '0;
      end else if (s1_op_ff == OP_INT_DIV) begin
         cell_in.is_div = !s1_nz_ff;
         cell_in.div_zero = s1_nz_ff;
         cell_in.dividend = {{FRACTION_BITS{1'b0}}, s1_ma_ff};
         cell_in.divisor = s1_mn_ff;
         cell_in.early = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

### rtl/fixed_point_alu.sv
// Throughput: one transaction per cycle; the front end, the 78 divider cells
// and the output register all advance together whenever the output can move.
// The pipeline depth is set by the chain of one-bit restoring division cells.
// Reset: synchronous, active high; it clears every valid bit and so empties
// the pipeline. No response is presented during or straight after reset.
module fixed_point_alu (
   input logic clock,
   input logic reset,
   fpa_req_if.sink   req,
   fpa_rsp_if.source rsp
);
   import fpa_pkg::*;

   cell_type                chain [CELL_COUNT+1];
   logic                    advance;
   logic                    out_valid_ff;
   logic [DATA_WIDTH-1:0]   out_result_ff;
   logic                    out_dbz_ff;
   logic [DATA_WIDTH-1:0]   final_w;
   logic [DATA_WIDTH-1:0]   quo_w;

   // The whole pipe stalls only when a response is held and not taken.
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   fpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req.valid),
      .operation   (req.operation),
      .operand_a   (req.operand_a),
      .operand_b   (req.operand_b),
      .int_operand (req.int_operand),
      .cell_out    (chain[0])
   );

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      fpa_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   always_comb begin
      quo_w = chain[CELL_COUNT].quotient[DATA_WIDTH-1:0];
      if (chain[CELL_COUNT].is_div) begin
         final_w = chain[CELL_COUNT].negate ? (~quo_w + 1'b1) : quo_w;
      end else begin
         final_w = chain[CELL_COUNT].early;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[CELL_COUNT].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= final_w;
         out_dbz_ff <= chain[CELL_COUNT].div_zero;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.result = out_result_ff;
   assign rsp.divide_by_zero = out_dbz_ff;

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dbz_ff) |-> (out_result_ff == '0))
      else $error("divide-by-zero response carries a non-zero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> (out_valid_ff && $stable(out_result_ff)))
      else $error("stalled response changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req.ready)
      else $error("request refused with an empty output register");

endmodule

### test/tb_fixed_point_alu.sv
module tb_fixed_point_alu;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   typedef struct {
      logic [3:0]            operation;
      logic [DATA_WIDTH-1:0] operand_a;
      logic [DATA_WIDTH-1:0] operand_b;
      logic [INT_WIDTH-1:0]  int_operand;
   } alu_op_type;

   typedef struct {
      logic [DATA_WIDTH-1:0] result;
      logic                  divide_by_zero;
   } alu_res_type;

   localparam int RANDOM_OPS = 1650;
   localparam int QUIET_TAIL = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpa_req_if req ();
   fpa_rsp_if rsp ();

   fixed_point_alu u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #6 clock = ~clock;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          mismatches = 0;
   int          results_seen = 0;
   bit          req_taken = 1'b0;
   int          idle_cycles = 0;

   // Bit-exact model of one operation of the ALU.
   function automatic alu_res_type compute_result(alu_op_type op);
      alu_res_type           r;
      logic [DATA_WIDTH-1:0] n64, scaled_n, ma, mb, mag;
      logic [127:0]          prod, dividend;
      bit                    na, nb;
      n64      = {{32{op.int_operand[31]}}, op.int_operand};
      scaled_n = n64 << FRACTION_BITS;
      na       = op.operand_a[63];
      nb       = op.operand_b[63];
      ma       = na ? -op.operand_a : op.operand_a;
      mb       = nb ? -op.operand_b : op.operand_b;
      r.result = '0;
      r.divide_by_zero = 1'b0;
      case (op.operation)
         OP_FROM_INT: r.result = scaled_n;
         OP_TO_INT_RZ, OP_TO_INT_RN: begin
            if (op.operation == OP_TO_INT_RN)
               mag = (ma + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            else
               mag = ma >> FRACTION_BITS;
            mag = na ? -mag : mag;
            r.result = {{32{mag[31]}}, mag[31:0]};
         end
         OP_ADD: r.result = op.operand_a + op.operand_b;
         OP_SUB: r.result = op.operand_a - op.operand_b;
         OP_MUL: begin
            prod = {64'd0, ma} * {64'd0, mb};
            mag = prod[FRACTION_BITS +: 64];
            r.result = (na != nb) ? -mag : mag;
         end
         OP_DIV: begin
            if (op.operand_b == '0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               dividend = {64'd0, ma} << FRACTION_BITS;
               prod = dividend / {64'd0, mb};
               mag = prod[63:0];
               r.result = (na != nb) ? -mag : mag;
            end
         end
         OP_INT_ADD: r.result = op.operand_a + scaled_n;
         OP_INT_SUB: r.result = op.operand_a - scaled_n;
         OP_INT_MUL: r.result = op.operand_a * n64;
         OP_INT_DIV: begin
            if (op.int_operand == '0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               mb = n64[63] ? -n64 : n64;
               mag = ma / mb;
               r.result = (na != n64[63]) ? -mag : mag;
            end
         end
         default: r.result = '0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand_fixed();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'(signed'($urandom_range(0, 200000)) - 100000);
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         4: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom};
         default: return 64'(signed'($urandom_range(0, 10)) - 5) << FRACTION_BITS;
      endcase
   endfunction

   function automatic logic [31:0] rand_int();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return 32'(signed'($urandom_range(0, 20)) - 10);
         3: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'd0;
      endcase
   endfunction

   task automatic add_op(logic [3:0] code, logic [63:0] a, logic [63:0] b, logic [31:0] n);
      alu_op_type op;
      op.operation   = code;
      op.operand_a   = a;
      op.operand_b   = b;
      op.int_operand = n;
      pending_ops.push_back(op);
   endtask

   // Driver: a new transaction is offered at the falling edge once the last one is taken, after any random gap.
   int gap_count = 0;
   always @(negedge clock) begin
      if (!reset && (!req.valid || req_taken)) begin
         if (gap_count > 0) begin
            gap_count = gap_count - 1;
            req.valid <= 1'b0;
         end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            gap_count = $urandom_range(0, 7);
            req.valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            alu_op_type op;
            op = pending_ops.pop_front();
            req.valid       <= 1'b1;
            req.operation   <= op.operation;
            req.operand_a   <= op.operand_a;
            req.operand_b   <= op.operand_b;
            req.int_operand <= op.int_operand;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, with one long hold-off so the pipeline fills up.
   int  stall_count = 0;
   bit  hold_off_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_count > 0) begin
         stall_count = stall_count - 1;
         rsp.ready <= 1'b0;
      end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         stall_count = HOLD_OFF_CYCLES - 1;
         rsp.ready <= 1'b0;
      end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         stall_count = $urandom_range(0, 7);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted requests and checks each response transaction.
   always @(posedge clock) begin
      alu_res_type want;
      alu_op_type  op;
      req_taken = 1'b0;
      if (!reset) begin
         if (req.valid && req.ready) begin
            req_taken = 1'b1;
            op.operation   = req.operation;
            op.operand_a   = req.operand_a;
            op.operand_b   = req.operand_b;
            op.int_operand = req.int_operand;
            expected_results.push_back(compute_result(op));
         end
         if (rsp.valid && rsp.ready) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected response result=%h flag=%b", $realtime,
                        rsp.result, rsp.divide_by_zero);
            end else begin
               want = expected_results.pop_front();
               if (rsp.result !== want.result) begin
                  mismatches = mismatches + 1;
                  $display("%0t: result expected %h actual %h", $realtime,
                           want.result, rsp.result);
               end
               if (rsp.divide_by_zero !== want.divide_by_zero) begin
                  mismatches = mismatches + 1;
                  $display("%0t: divide_by_zero expected %b actual %b", $realtime,
                           want.divide_by_zero, rsp.divide_by_zero);
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] min64, max64;
      int          code;
      min64 = 64'h8000_0000_0000_0000;
      max64 = 64'h7FFF_FFFF_FFFF_FFFF;
      req.valid       = 1'b0;
      req.operation   = '0;
      req.operand_a   = '0;
      req.operand_b   = '0;
      req.int_operand = '0;
      rsp.ready       = 1'b0;

      // Directed: extremes per operation, zero divisors, most negative over -1, unused codes 11 to 15.
      add_op(OP_FROM_INT, '0, '0, 32'h8000_0000);
      add_op(OP_FROM_INT, '0, '0, 32'h7FFF_FFFF);
      add_op(OP_TO_INT_RZ, min64, '0, '0);
      add_op(OP_TO_INT_RZ, -64'sd24577, '0, '0);
      add_op(OP_TO_INT_RN, max64, '0, '0);
      add_op(OP_TO_INT_RN, -64'sd8192, '0, '0);
      add_op(OP_TO_INT_RN, 64'd8191, '0, '0);
      add_op(OP_ADD, max64, 64'd1, '0);
      add_op(OP_SUB, min64, 64'd1, '0);
      add_op(OP_MUL, min64, min64, '0);
      add_op(OP_MUL, max64, -64'sd16384, '0);
      add_op(OP_DIV, max64, '0, '0);
      add_op(OP_DIV, min64, -64'sd16384, '0);
      add_op(OP_DIV, 64'd1, max64, '0);
      add_op(OP_INT_ADD, max64, '0, 32'h7FFF_FFFF);
      add_op(OP_INT_SUB, min64, '0, 32'h8000_0000);
      add_op(OP_INT_MUL, min64, '0, 32'hFFFF_FFFF);
      add_op(OP_INT_DIV, min64, '0, 32'hFFFF_FFFF);
      add_op(OP_INT_DIV, max64, '0, '0);
      add_op(OP_INT_DIV, -64'sd7, '0, 32'd2);
      for (code = 11; code <= 15; code++)
         add_op(4'(code), max64, min64, 32'hFFFF_FFFF);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if ($urandom_range(0, 19) == 0)
            code = $urandom_range(11, 15);
         else
            code = $urandom_range(0, 10);
         add_op(4'(code), rand_fixed(), rand_fixed(), rand_int());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b1;
      @(negedge clock);
      reset = 1'b0;

      while (pending_ops.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

### fixed_point_alu.f
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_div_cell.sv
rtl/fpa_front.sv
rtl/fixed_point_alu.sv
test/tb_fixed_point_alu.sv
